// ----- src/jdfb_pkg.sv -----
package jdfb_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		K_DATA     = 3'd0,
		K_END_OK   = 3'd1,
		K_BAD_QUAD = 3'd2,
		K_TRUNC    = 3'd3,
		K_END_ERR  = 3'd4
	} kind_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_PAD    = 8'h3D;
	localparam logic [7:0] CH_N      = 8'h6E;

	localparam logic [7:0] KEY_TEXT [6] = '{8'h22, 8'h64, 8'h61, 8'h74, 8'h61, 8'h22};
	localparam logic [7:0] NULL_TEXT [4] = '{8'h6E, 8'h75, 8'h6C, 8'h6C};

	// one queue slot: a single result, or up to three decoded bytes
	typedef struct packed {
		kind_t       kind;
		logic [1:0]  cnt;
		logic [23:0] data;
	} entry_t;

	function automatic logic is_ws(input logic [7:0] c);
		return c inside {8'h20, [8'h09:8'h0D]};
	endfunction

	// 0..63 for alphabet characters, bit 6 set for anything else
	function automatic logic [6:0] b64_value(input logic [7:0] c);
		if (c inside {[8'h41:8'h5A]}) return {1'b0, 6'(c - 8'h41)};
		if (c inside {[8'h61:8'h7A]}) return {1'b0, 6'(c - 8'h47)};
		if (c inside {[8'h30:8'h39]}) return {1'b0, 6'(c + 8'h04)};
		if (c == 8'h2B) return 7'd62;
		if (c == 8'h2F) return 7'd63;
		return 7'd64;
	endfunction

endpackage

// ----- src/jdfb_if.sv -----
interface jdfb_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] body_byte;

	modport source(output valid, output op, output body_byte, input ready);
	modport sink(input valid, input op, input body_byte, output ready);
endinterface

interface jdfb_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] out_byte;
	logic       last;

	modport source(output valid, output kind, output out_byte, output last, input ready);
	modport sink(input valid, input kind, input out_byte, input last, output ready);
endinterface

// ----- src/jdfb_front.sv -----
module jdfb_front (
	input  logic            clk,
	input  logic            arst_n,
	jdfb_in_if.sink         body,
	output logic            q_push,
	output jdfb_pkg::entry_t q_entry,
	input  logic            q_space
);
	import jdfb_pkg::*;

	typedef enum logic [4:0] {
		PH_SEARCH       = 5'b00001,
		PH_AFTER_KEY    = 5'b00010,
		PH_BEFORE_VALUE = 5'b00100,
		PH_IN_DATA      = 5'b01000,
		PH_SKIP_NULL    = 5'b10000
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [2:0] key_q, key_n;
	logic [1:0] null_q, null_n;
	logic       esc_q, esc_n;
	logic [1:0] qcnt_q, qcnt_n;
	logic       failed_q, failed_n;
	logic [7:0] quad_q [3];
	logic       store;

	logic       accept;
	logic       push_req;
	logic [7:0] c;
	logic       take;
	logic [6:0] v0, v1, v2, v3;
	logic       pad2, pad3;
	logic       dec3, dec2, dec1;

	assign body.ready = q_space;
	assign accept = body.valid & body.ready;
	assign c = body.body_byte;

	// push only on an accepted beat
	assign q_push = accept & push_req;

	assign v0 = b64_value(quad_q[0]);
	assign v1 = b64_value(quad_q[1]);
	assign v2 = b64_value(quad_q[2]);
	assign v3 = b64_value(c);
	assign pad2 = quad_q[2] == CH_PAD;
	assign pad3 = c == CH_PAD;
	assign dec3 = !v0[6] && !v1[6] && !v2[6] && !v3[6];
	assign dec2 = !v0[6] && !v1[6] && !v2[6] && pad3;
	assign dec1 = !v0[6] && !v1[6] && pad2 && pad3;

	always_comb begin
		phase_n  = phase_q;
		key_n    = key_q;
		null_n   = null_q;
		esc_n    = esc_q;
		qcnt_n   = qcnt_q;
		failed_n = failed_q;
		push_req = 1'b0;
		q_entry  = '{kind: K_DATA, cnt: 2'd1, data: 24'd0};
		take     = 1'b0;
		store    = 1'b0;
		if (body.op) begin
			push_req = 1'b1;
			if (failed_q)
				q_entry.kind = K_END_ERR;
			else if (phase_q == PH_IN_DATA && qcnt_q != 2'd0)
				q_entry.kind = K_TRUNC;
			else
				q_entry.kind = K_END_OK;
			phase_n  = PH_SEARCH;
			key_n    = 3'd0;
			null_n   = 2'd0;
			esc_n    = 1'b0;
			qcnt_n   = 2'd0;
			failed_n = 1'b0;
		end else if (!failed_q) begin
			case (phase_q)
				PH_AFTER_KEY: begin
					if (c == CH_COLON)
						phase_n = PH_BEFORE_VALUE;
					else if (!is_ws(c))
						phase_n = PH_SEARCH;
				end
				PH_BEFORE_VALUE: begin
					if (!is_ws(c)) begin
						if (c == CH_QUOTE) begin
							phase_n = PH_IN_DATA;
							esc_n   = 1'b0;
							qcnt_n  = 2'd0;
						end else if (c == CH_N) begin
							phase_n = PH_SKIP_NULL;
							null_n  = 2'd1;
						end else begin
							phase_n = PH_SEARCH;
						end
					end
				end
				PH_IN_DATA: begin
					if (esc_q) begin
						esc_n = 1'b0;
						take  = 1'b1;
					end else if (c == CH_BSLASH) begin
						esc_n = 1'b1;
					end else if (c == CH_QUOTE) begin
						phase_n = PH_SEARCH;
						if (qcnt_q != 2'd0) begin
							qcnt_n       = 2'd0;
							failed_n     = 1'b1;
							push_req     = 1'b1;
							q_entry.kind = K_TRUNC;
						end
					end else begin
						take = 1'b1;
					end
				end
				PH_SKIP_NULL: begin
					if (c == NULL_TEXT[null_q]) begin
						null_n = null_q + 2'd1;
						if (null_q == 2'd3)
							phase_n = PH_SEARCH;
					end else begin
						phase_n = PH_SEARCH;
					end
				end
				default: begin
					if (c == KEY_TEXT[key_q]) begin
						if (key_q == 3'd5) begin
							key_n   = 3'd0;
							phase_n = PH_AFTER_KEY;
						end else begin
							key_n = key_q + 3'd1;
						end
					end else begin
						key_n = (c == CH_QUOTE) ? 3'd1 : 3'd0;
					end
				end
			endcase
			if (take && !is_ws(c)) begin
				if (qcnt_q == 2'd3) begin
					push_req = 1'b1;
					qcnt_n   = 2'd0;
					if (dec3 || dec2 || dec1) begin
						q_entry.cnt  = dec3 ? 2'd3 : (dec2 ? 2'd2 : 2'd1);
						q_entry.data = {v0[5:0], v1[5:0], pad2 ? 6'd0 : v2[5:0],
							pad3 ? 6'd0 : v3[5:0]};
					end else begin
						q_entry.kind = K_BAD_QUAD;
						failed_n     = 1'b1;
					end
				end else begin
					store  = 1'b1;
					qcnt_n = qcnt_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEARCH;
			key_q    <= 3'd0;
			null_q   <= 2'd0;
			esc_q    <= 1'b0;
			qcnt_q   <= 2'd0;
			failed_q <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_n;
			key_q    <= key_n;
			null_q   <= null_n;
			esc_q    <= esc_n;
			qcnt_q   <= qcnt_n;
			failed_q <= failed_n;
		end
	end

	// hold the first three characters of a group; the fourth decodes on arrival
	always_ff @(posedge clk) begin
		if (accept && store)
			quad_q[qcnt_q] <= c;
	end

endmodule

// ----- src/jdfb_queue.sv -----
module jdfb_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jdfb_pkg::entry_t push_entry,
	output logic             space,
	input  logic             pop,
	output logic             avail,
	output jdfb_pkg::entry_t pop_entry
);
	import jdfb_pkg::*;

	entry_t         mem [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   level_q;

	assign space = level_q != (QAW+1)'(QDEPTH);
	assign avail = level_q != '0;
	assign pop_entry = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wp_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			level_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == QAW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == QAW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)
				level_q <= level_q + 1'b1;
			else if (pop && !push)
				level_q <= level_q - 1'b1;
		end
	end

endmodule

// ----- src/jdfb_back.sv -----
module jdfb_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_avail,
	input  jdfb_pkg::entry_t q_entry,
	output logic             q_pop,
	jdfb_out_if.source       result
);
	import jdfb_pkg::*;

	entry_t     cur_q;
	logic       cur_vld_q;
	logic [1:0] idx_q;
	logic       out_vld_q;
	logic [2:0] kind_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic       out_free;
	logic       emit;
	logic       cur_last;
	logic [7:0] sel_byte;

	assign out_free = !out_vld_q || result.ready;
	assign emit     = cur_vld_q && out_free;
	assign cur_last = idx_q == (cur_q.cnt - 2'd1);
	assign q_pop    = q_avail && (!cur_vld_q || (emit && cur_last));

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = cur_q.data[23:16];
			2'd1:    sel_byte = cur_q.data[15:8];
			default: sel_byte = cur_q.data[7:0];
		endcase
	end

	assign result.valid    = out_vld_q;
	assign result.kind     = kind_q;
	assign result.out_byte = byte_q;
	assign result.last     = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= 2'd0;
			out_vld_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_vld_q <= 1'b1;
				idx_q     <= 2'd0;
			end else if (emit && cur_last) begin
				cur_vld_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 2'd1;
			end
			if (emit)
				out_vld_q <= 1'b1;
			else if (result.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_entry;
		if (emit) begin
			kind_q <= cur_q.kind;
			byte_q <= (cur_q.kind == K_DATA) ? sel_byte : 8'd0;
			last_q <= cur_last;
		end
	end

endmodule

// ----- src/json_data_field_base64_extractor_unit.sv -----
// Streaming extractor for the base64 "data" field of a JSON body.
// body: one beat per body byte (op = 0) or an end-of-body marker (op = 1).
//   The parser takes one beat per cycle; ready drops only when the
//   four-entry result queue between parser and output side is full.
// result: one beat per result (kind, out_byte, last). A decoded group of
//   four characters gives one to three data beats, errors and the end
//   marker give one beat each; last marks the final beat of a body beat.
// Path: a body beat that yields results reaches the result port through
//   the queue slot written at the accepting edge, then the unpack register,
//   then the output register; further beats follow one per cycle while ready.
// Throughput: one body beat per cycle; result beats leave at one per
//   cycle, and since a group needs at least four body beats for at most
//   three result beats, the output side keeps up while the receiver does.
// Reset: arst_n clears the parser to key search, empties the queue and
//   drops any pending result. When the receiver stalls, the output register
//   holds its beat, the queue fills and body.ready then goes low.
module json_data_field_base64_extractor_unit (
	input  logic       clk,
	input  logic       arst_n,
	jdfb_in_if.sink    body,
	jdfb_out_if.source result
);
	import jdfb_pkg::*;

	logic   q_push, q_space, q_pop, q_avail;
	entry_t push_entry, pop_entry;

	jdfb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.body    (body),
		.q_push  (q_push),
		.q_entry (push_entry),
		.q_space (q_space)
	);

	jdfb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.space      (q_space),
		.pop        (q_pop),
		.avail      (q_avail),
		.pop_entry  (pop_entry)
	);

	jdfb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_avail (q_avail),
		.q_entry (pop_entry),
		.q_pop   (q_pop),
		.result  (result)
	);

	a_end_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(body.valid && body.ready && body.op) |-> q_push)
		else $error("end beat did not queue a result");

	a_pop_avail: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_avail)
		else $error("pop from empty queue");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.kind != K_DATA) |-> (result.out_byte == 8'd0 && result.last))
		else $error("status beat with data byte or without last");

endmodule

// ----- tb/sv/json_data_field_base64_extractor_unit_tb.sv -----
`timescale 1ns / 100ps

module json_data_field_base64_extractor_unit_tb;
	import jdfb_pkg::*;

	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 80;
	localparam int BODY_BEATS   = 370;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;

	localparam logic [2:0] PH_SEARCH       = 3'd0;
	localparam logic [2:0] PH_AFTER_KEY    = 3'd1;
	localparam logic [2:0] PH_BEFORE_VALUE = 3'd2;
	localparam logic [2:0] PH_IN_DATA      = 3'd3;
	localparam logic [2:0] PH_SKIP_NULL    = 3'd4;

	typedef struct packed {
		logic       op;
		logic [7:0] c;
	} body_beat_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} decoded_t;

	logic clk = 1'b0;
	logic arst_n;

	jdfb_in_if  body_ch ();
	jdfb_out_if result_ch ();

	json_data_field_base64_extractor_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.body   (body_ch),
		.result (result_ch)
	);

	always #5 clk = ~clk;

	body_beat_t body_beats [$];
	decoded_t   decoded_q [$];
	body_beat_t next_beat;
	decoded_t   want;
	int total_beats;
	int accepted_beats;
	int mismatches;
	int tx_pause, tx_calm, rx_stall, rx_calm;
	int hold_left;
	bit held;
	int idle_cycles;

	// parser copy
	logic [2:0] phase;
	int         key_pos;
	int         null_pos;
	bit         esc;
	logic [7:0] quad [4];
	int         quad_n;
	bit         sticky;

	function automatic bit blank(input logic [7:0] c);
		case (c)
			8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [6:0] sextet(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
		if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26);
		if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
		if (c == 8'h2B) return 7'd62;
		if (c == 8'h2F) return 7'd63;
		return 7'd64;
	endfunction

	function automatic logic [7:0] b64_char(input int i);
		if (i < 26) return 8'(8'h41 + i);
		if (i < 52) return 8'(8'h61 + i - 26);
		if (i < 62) return 8'(8'h30 + i - 52);
		return (i == 62) ? 8'h2B : 8'h2F;
	endfunction

	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function void clear_parser();
		phase = PH_SEARCH;
		key_pos = 0;
		null_pos = 0;
		esc = 1'b0;
		quad_n = 0;
		sticky = 1'b0;
	endfunction

	function void add_result(input kind_t k, input logic [7:0] d, input logic l);
		decoded_q.push_back('{k, d, l});
	endfunction

	function void unpack_group();
		logic [23:0] acc;
		logic [6:0]  v;
		int          pads;
		bit          bad;
		acc = '0;
		pads = 0;
		bad = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (quad[i] == CH_PAD) begin
				pads++;
				v = '0;
				if (pads > 2) bad = 1'b1;
			end else begin
				v = sextet(quad[i]);
				if (pads != 0 || v[6]) bad = 1'b1;
			end
			acc = {acc[17:0], v[5:0]};
		end
		if (bad) begin
			sticky = 1'b1;
			add_result(K_BAD_QUAD, 8'h00, 1'b1);
			return;
		end
		quad_n = 0;
		for (int i = 0; i < 3 - pads; i++)
			add_result(K_DATA, acc[23 - 8 * i -: 8], i == 2 - pads);
	endfunction

	function void take_char(input logic [7:0] c);
		if (blank(c)) return;
		quad[quad_n] = c;
		quad_n++;
		if (quad_n == 4) unpack_group();
	endfunction

	function void decode_body_beat(input logic op, input logic [7:0] c);
		if (op == OP_END) begin
			if (sticky) add_result(K_END_ERR, 8'h00, 1'b1);
			else if (phase == PH_IN_DATA && quad_n != 0) add_result(K_TRUNC, 8'h00, 1'b1);
			else add_result(K_END_OK, 8'h00, 1'b1);
			clear_parser();
			return;
		end
		if (sticky) return;
		case (phase)
			PH_AFTER_KEY: begin
				if (c == CH_COLON) phase = PH_BEFORE_VALUE;
				else if (!blank(c)) phase = PH_SEARCH;
			end
			PH_BEFORE_VALUE: begin
				if (!blank(c)) begin
					if (c == CH_QUOTE) begin
						phase = PH_IN_DATA;
						esc = 1'b0;
						quad_n = 0;
					end else if (c == CH_N) begin
						phase = PH_SKIP_NULL;
						null_pos = 1;
					end else begin
						phase = PH_SEARCH;
					end
				end
			end
			PH_IN_DATA: begin
				if (esc) begin
					esc = 1'b0;
					take_char(c);
				end else if (c == CH_BSLASH) begin
					esc = 1'b1;
				end else if (c == CH_QUOTE) begin
					phase = PH_SEARCH;
					if (quad_n != 0) begin
						quad_n = 0;
						sticky = 1'b1;
						add_result(K_TRUNC, 8'h00, 1'b1);
					end
				end else begin
					take_char(c);
				end
			end
			PH_SKIP_NULL: begin
				if (null_pos < 4 && c == NULL_TEXT[null_pos]) begin
					null_pos++;
					if (null_pos == 4) phase = PH_SEARCH;
				end else begin
					phase = PH_SEARCH;
				end
			end
			default: begin
				if (key_pos < 6 && c == KEY_TEXT[key_pos]) begin
					key_pos++;
					if (key_pos == 6) begin
						key_pos = 0;
						phase = PH_AFTER_KEY;
					end
				end else begin
					key_pos = (c == CH_QUOTE) ? 1 : 0;
				end
			end
		endcase
	endfunction

	task automatic queue_beat(input logic op, input logic [7:0] c);
		body_beats.push_back('{op, c});
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++) queue_beat(OP_BYTE, s[i]);
	endtask

	task automatic queue_blanks(input int n);
		int k;
		repeat (n) begin
			k = $urandom_range(0, 5);
			queue_beat(OP_BYTE, (k == 5) ? 8'h20 : 8'(8'h09 + k));
		end
	endtask

	// one group of four, mostly valid, sometimes padded, broken, escaped or split by blanks
	task automatic queue_group();
		logic [7:0] g [4];
		int style;
		style = $urandom_range(0, 19);
		for (int i = 0; i < 4; i++) g[i] = b64_char($urandom_range(0, 63));
		if (style < 3) begin
			g[3] = CH_PAD;
		end else if (style < 5) begin
			g[2] = CH_PAD;
			g[3] = CH_PAD;
		end else if (style == 5) begin
			g[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
		end else if (style == 6) begin
			g[$urandom_range(0, 2)] = CH_PAD;
		end else if (style == 7) begin
			for (int i = 0; i < 4; i++) g[i] = CH_PAD;
		end
		for (int i = 0; i < 4; i++) begin
			if ($urandom_range(0, 9) == 0) queue_blanks(1);
			if ($urandom_range(0, 29) == 0) begin
				queue_beat(OP_BYTE, CH_BSLASH);
				queue_blanks(1);
			end
			if ($urandom_range(0, 11) == 0) queue_beat(OP_BYTE, CH_BSLASH);
			queue_beat(OP_BYTE, g[i]);
		end
	endtask

	task automatic queue_random_body();
		string prefix_chars;
		int    shape;
		int    value;
		prefix_chars = "{\" ,:}ad";
		shape = $urandom_range(0, 9);
		if (shape == 0) begin
			repeat ($urandom_range(1, 8)) queue_beat(OP_BYTE, 8'($urandom_range(0, 255)));
			queue_beat(OP_END, 8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 3))
			queue_beat(OP_BYTE, prefix_chars[$urandom_range(0, prefix_chars.len() - 1)]);
		if ($urandom_range(0, 9) == 0) queue_text("\"dat\"");
		else queue_text("\"data\"");
		queue_blanks($urandom_range(0, 2));
		queue_beat(OP_BYTE, ($urandom_range(0, 19) == 0) ? 8'h78 : CH_COLON);
		queue_blanks($urandom_range(0, 2));
		value = $urandom_range(0, 9);
		if (value == 0) begin
			if ($urandom_range(0, 2) == 0) queue_text("nux");
			else queue_text("null");
		end else if (value == 1) begin
			queue_text("12");
		end else begin
			queue_beat(OP_BYTE, CH_QUOTE);
			repeat ($urandom_range(1, 4)) queue_group();
			if ($urandom_range(0, 6) == 0)
				repeat ($urandom_range(1, 3)) queue_beat(OP_BYTE, b64_char($urandom_range(0, 63)));
			if ($urandom_range(0, 6) != 0) begin
				queue_beat(OP_BYTE, CH_QUOTE);
				if ($urandom_range(0, 1) == 0) queue_text("}");
			end
		end
		queue_beat(OP_END, 8'($urandom_range(0, 255)));
	endtask

	// sender: offer the next body beat, pausing at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_ch.valid <= 1'b0;
			body_ch.op <= OP_BYTE;
			body_ch.body_byte <= 8'h00;
			tx_pause <= 0;
			tx_calm <= 0;
			accepted_beats <= 0;
			decoded_q.delete();
			clear_parser();
		end else begin
			if (body_ch.valid && body_ch.ready) begin
				decode_body_beat(body_ch.op, body_ch.body_byte);
				accepted_beats <= accepted_beats + 1;
			end
			if (!body_ch.valid || body_ch.ready) begin
				if (tx_pause != 0 && hold_left == 0) begin
					tx_pause <= tx_pause - 1;
					body_ch.valid <= 1'b0;
				end else if (body_beats.size() != 0) begin
					next_beat = body_beats.pop_front();
					body_ch.valid <= 1'b1;
					body_ch.op <= next_beat.op;
					body_ch.body_byte <= next_beat.c;
					if (tx_calm != 0) begin
						tx_calm <= tx_calm - 1;
						tx_pause <= 0;
					end else if ($urandom_range(0, 39) == 0) begin
						tx_calm <= $urandom_range(30, 80);
						tx_pause <= 0;
					end else begin
						tx_pause <= pick_pause();
					end
				end else begin
					body_ch.valid <= 1'b0;
				end
			end
		end
	end

	// one long receiver hold-off once results are queued up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			held <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!held && accepted_beats > 30 && decoded_q.size() >= 3) begin
			hold_left <= HOLD_CYCLES;
			held <= 1'b1;
		end
	end

	// receiver: check each result beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			rx_stall <= 0;
			rx_calm <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (decoded_q.size() == 0) begin
					$error("unexpected result beat: kind %0d, out_byte %02h, last %0b",
						result_ch.kind, result_ch.out_byte, result_ch.last);
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					if (result_ch.kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, result_ch.kind);
						mismatches++;
					end
					if (result_ch.out_byte !== want.data) begin
						$error("out_byte: expected %02h, actual %02h",
							want.data, result_ch.out_byte);
						mismatches++;
					end
					if (result_ch.last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, result_ch.last);
						mismatches++;
					end
				end
			end
			if (hold_left != 0) begin
				result_ch.ready <= 1'b0;
			end else if (rx_stall != 0) begin
				rx_stall <= rx_stall - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if (rx_calm != 0) rx_calm <= rx_calm - 1;
				else if ($urandom_range(0, 59) == 0) rx_calm <= $urandom_range(30, 100);
				else if ($urandom_range(0, 4) == 0) rx_stall <= pick_pause();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (body_ch.valid && body_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;

		// extreme bytes, quote restart of the key, blank before the colon, a two-byte
		// group, escaped char left partial at the closing quote, byte while failed
		queue_beat(OP_BYTE, 8'h00);
		queue_beat(OP_BYTE, 8'hFF);
		queue_text("\"\"data\" :\"/+9=\\A\"x");
		queue_beat(OP_END, 8'hFF);

		while (body_beats.size() < BODY_BEATS) queue_random_body();
		total_beats = body_beats.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_beats != total_beats || decoded_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ----- json_data_field_base64_extractor_unit.f -----
src/jdfb_pkg.sv
src/jdfb_if.sv
src/jdfb_front.sv
src/jdfb_queue.sv
src/jdfb_back.sv
src/json_data_field_base64_extractor_unit.sv
tb/sv/json_data_field_base64_extractor_unit_tb.sv
